FILE: rtl/rdv_pkg.sv
// Shared constants and types for the refraction direction pipeline.
package rdv_pkg;

    localparam int F     = 16;
    localparam int DW    = 20;
    localparam int EW    = 19;
    localparam int PW    = 2 * DW;
    localparam int DOTW  = PW + 2;
    localparam int CW    = (DOTW - F + 1 > F + 2) ? DOTW - F + 1 : F + 2;
    localparam int CPW   = CW + DW;
    localparam int TW    = CPW - F + 1;
    localparam int SW    = ((TW > DW) ? TW : DW) + 1;
    localparam int QW    = SW + EW + 1;
    localparam int PRW   = 32;
    localparam int SQW   = 2 * PRW;
    localparam int RW    = PRW;
    localparam int MW    = RW + 1 + DW;
    localparam int NSQ   = SQW / 2;
    localparam int HALF  = 1 << (F - 1);
    localparam int ONE   = 1 << F;
    localparam longint PERP_LIM = 64'sd2147483647;
    localparam int OUT_MAX = (1 << (DW - 1)) - 1;
    localparam int OUT_MIN = -(1 << (DW - 1));

    typedef logic signed [DW-1:0]  t_comp;
    typedef logic signed [PRW-1:0] t_perp;

    typedef struct packed {
        t_comp n0;
        t_comp n1;
        t_comp n2;
        t_perp p0;
        t_perp p1;
        t_perp p2;
        logic  sat;
    } t_lane;

endpackage

FILE: rtl/refract_direction_vector.sv
// Top level of the Snell refraction pipeline.
//  channel | handshake             | payload
//  in      | i_valid / o_stall     | i_dir_*, i_norm_*, i_eta_ratio
//  out     | o_valid / i_stall     | o_out_*, o_saturated
// One transfer per cycle while the output is not stalled; 8 front stages,
// 32 square-root stages, 2 back stages.
// Reset clears only the valid bits of every stage.
// A stalled output holds the whole pipeline; o_stall follows it in the same cycle.
module refract_direction_vector
    import rdv_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [19:0]   i_dir_x,
    input  logic [19:0]   i_dir_y,
    input  logic [19:0]   i_dir_z,
    input  logic [19:0]   i_norm_x,
    input  logic [19:0]   i_norm_y,
    input  logic [19:0]   i_norm_z,
    input  logic [18:0]   i_eta_ratio,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [19:0]   o_out_x,
    output logic [19:0]   o_out_y,
    output logic [19:0]   o_out_z,
    output logic          o_saturated
);

    logic            w_en;
    t_comp           w_d [3];
    t_comp           w_n [3];
    logic            w_fv, w_sv;
    logic [SQW-1:0]  w_diff;
    t_lane           w_flane, w_slane;
    logic [RW-1:0]   w_root;
    t_comp           w_out [3];

    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    assign w_d[0] = i_dir_x;
    assign w_d[1] = i_dir_y;
    assign w_d[2] = i_dir_z;
    assign w_n[0] = i_norm_x;
    assign w_n[1] = i_norm_y;
    assign w_n[2] = i_norm_z;

    rdv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_d     (w_d),
        .i_n     (w_n),
        .i_eta   (i_eta_ratio),
        .o_valid (w_fv),
        .o_diff  (w_diff),
        .o_lane  (w_flane)
    );

    rdv_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_fv),
        .i_x     (w_diff),
        .i_lane  (w_flane),
        .o_valid (w_sv),
        .o_root  (w_root),
        .o_lane  (w_slane)
    );

    rdv_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sv),
        .i_root  (w_root),
        .i_lane  (w_slane),
        .o_valid (o_valid),
        .o_out   (w_out),
        .o_sat   (o_saturated)
    );

    assign o_out_x = w_out[0];
    assign o_out_y = w_out[1];
    assign o_out_z = w_out[2];

endmodule

FILE: rtl/rdv_front.sv
// Front stages: cosine, perpendicular part and the radicand.
module rdv_front
    import rdv_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  t_comp            i_d [3],
    input  t_comp            i_n [3],
    input  logic [EW-1:0]    i_eta,
    output logic             o_valid,
    output logic [SQW-1:0]   o_diff,
    output t_lane            o_lane
);

    logic [7:0]               r_v;
    logic signed [PW-1:0]     r1_prod [3];
    t_comp                    r1_d [3], r2_d [3], r3_d [3];
    t_comp                    r_n1 [3], r_n2 [3], r_n3 [3], r_n4 [3], r_n5 [3];
    t_comp                    r_n6 [3], r_n7 [3], r_n8 [3];
    logic [EW-1:0]            r1_eta, r2_eta, r3_eta, r4_eta;
    logic signed [CW-1:0]     r2_cos;
    logic signed [CPW-1:0]    r3_p [3];
    logic signed [SW-1:0]     r4_s [3];
    logic signed [QW-1:0]     r5_q [3];
    t_perp                    r6_perp [3], r7_perp [3], r8_perp [3];
    logic                     r6_sat, r7_sat, r8_sat;
    logic [SQW-1:0]           r7_sq [3];
    logic [SQW-1:0]           r8_diff;

    logic signed [DOTW-1:0]   n_dot;
    logic signed [DOTW:0]     n_negh;
    logic signed [DOTW:0]     n_crs;
    logic signed [CW-1:0]     n_cos;
    logic signed [SW-1:0]     n_s [3];
    t_perp                    n_perp [3];
    logic                     n_sat;
    logic [SQW-1:0]           n_diff;

    always_comb begin
        logic signed [CPW:0] th;
        logic signed [QW:0]  qh;
        logic [SQW-1:0]      pp;
        n_dot  = DOTW'(r1_prod[0]) + DOTW'(r1_prod[1]) + DOTW'(r1_prod[2]);
        n_negh = -(DOTW+1)'(n_dot) + (DOTW+1)'(HALF);
        n_crs  = n_negh >>> F;
        n_cos  = (n_crs > (DOTW+1)'(ONE)) ? CW'(ONE) : CW'(n_crs);
        n_sat  = 1'b0;
        for (int i = 0; i < 3; i++) begin
            th = ((CPW+1)'(r3_p[i]) + (CPW+1)'(HALF)) >>> F;
            n_s[i] = SW'(r3_d[i]) + SW'(th);
            qh = ((QW+1)'(r5_q[i]) + (QW+1)'(HALF)) >>> F;
            if (qh > (QW+1)'(PERP_LIM)) begin
                n_perp[i] = PRW'(PERP_LIM);
                n_sat = 1'b1;
            end else if (qh < -(QW+1)'(PERP_LIM)) begin
                n_perp[i] = -PRW'(PERP_LIM);
                n_sat = 1'b1;
            end else begin
                n_perp[i] = PRW'(qh);
            end
        end
        pp = r7_sq[0] + r7_sq[1] + r7_sq[2];
        if (pp >= (SQW'(1) << (2 * F))) begin
            n_diff = pp - (SQW'(1) << (2 * F));
        end else begin
            n_diff = (SQW'(1) << (2 * F)) - pp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[6:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_prod[i] <= PW'(i_d[i] * i_n[i]);
                r1_d[i]    <= i_d[i];
                r2_d[i]    <= r1_d[i];
                r3_d[i]    <= r2_d[i];
                r_n1[i]    <= i_n[i];
                r_n2[i]    <= r_n1[i];
                r_n3[i]    <= r_n2[i];
                r_n4[i]    <= r_n3[i];
                r_n5[i]    <= r_n4[i];
                r_n6[i]    <= r_n5[i];
                r_n7[i]    <= r_n6[i];
                r_n8[i]    <= r_n7[i];
                r3_p[i]    <= CPW'(r2_cos * r_n2[i]);
                r4_s[i]    <= n_s[i];
                r5_q[i]    <= QW'($signed({1'b0, r4_eta}) * r4_s[i]);
                r6_perp[i] <= n_perp[i];
                r7_perp[i] <= r6_perp[i];
                r8_perp[i] <= r7_perp[i];
                r7_sq[i]   <= SQW'(r6_perp[i] * r6_perp[i]);
            end
            r1_eta  <= i_eta;
            r2_eta  <= r1_eta;
            r3_eta  <= r2_eta;
            r4_eta  <= r3_eta;
            r2_cos  <= n_cos;
            r6_sat  <= n_sat;
            r7_sat  <= r6_sat;
            r8_sat  <= r7_sat;
            r8_diff <= n_diff;
        end
    end

    assign o_valid = r_v[7];
    assign o_diff  = r8_diff;
    assign o_lane  = '{n0: r_n8[0], n1: r_n8[1], n2: r_n8[2],
                       p0: r8_perp[0], p1: r8_perp[1], p2: r8_perp[2], sat: r8_sat};

endmodule

FILE: rtl/rdv_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module rdv_sqrt
    import rdv_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [SQW-1:0] i_x,
    input  t_lane          i_lane,
    output logic           o_valid,
    output logic [RW-1:0]  o_root,
    output t_lane          o_lane
);

    logic [NSQ-1:0]  r_v;
    logic [SQW-1:0]  r_x [NSQ];
    logic [SQW-1:0]  r_r [NSQ];
    t_lane           r_lane [NSQ];
    logic [SQW-1:0]  n_x [NSQ];
    logic [SQW-1:0]  n_r [NSQ];

    always_comb begin
        logic [SQW-1:0] x, r, b;
        for (int k = 0; k < NSQ; k++) begin
            x = (k == 0) ? i_x : r_x[(k == 0) ? 0 : k - 1];
            r = (k == 0) ? '0  : r_r[(k == 0) ? 0 : k - 1];
            b = SQW'(1) << (SQW - 2 - 2 * k);
            if (x >= r + b) begin
                n_x[k] = x - (r + b);
                n_r[k] = (r >> 1) + b;
            end else begin
                n_x[k] = x;
                n_r[k] = r >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NSQ-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NSQ; k++) begin
                r_x[k] <= n_x[k];
                r_r[k] <= n_r[k];
            end
            r_lane[0] <= i_lane;
            for (int k = 1; k < NSQ; k++) begin
                r_lane[k] <= r_lane[k-1];
            end
        end
    end

    assign o_valid = r_v[NSQ-1];
    assign o_root  = r_r[NSQ-1][RW-1:0];
    assign o_lane  = r_lane[NSQ-1];

endmodule

FILE: rtl/rdv_back.sv
// Back stages: parallel part, final sum and output saturation.
module rdv_back
    import rdv_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [RW-1:0] i_root,
    input  t_lane         i_lane,
    output logic          o_valid,
    output t_comp         o_out [3],
    output logic          o_sat
);

    logic [1:0]            r_v;
    logic signed [MW-1:0]  r1_m [3];
    t_perp                 r1_perp [3];
    logic                  r1_sat;
    t_comp                 r2_out [3];
    logic                  r2_sat;
    t_comp                 w_n [3];
    t_perp                 w_p [3];
    t_comp                 n_out [3];
    logic                  n_sat;

    assign w_n[0] = i_lane.n0;
    assign w_n[1] = i_lane.n1;
    assign w_n[2] = i_lane.n2;
    assign w_p[0] = i_lane.p0;
    assign w_p[1] = i_lane.p1;
    assign w_p[2] = i_lane.p2;

    always_comb begin
        logic signed [MW:0]   mh;
        logic signed [MW+1:0] v;
        n_sat = r1_sat;
        for (int i = 0; i < 3; i++) begin
            mh = ((MW+1)'(r1_m[i]) + (MW+1)'(HALF)) >>> F;
            v  = (MW+2)'(r1_perp[i]) - (MW+2)'(mh);
            if (v > (MW+2)'(OUT_MAX)) begin
                n_out[i] = DW'(OUT_MAX);
                n_sat = 1'b1;
            end else if (v < (MW+2)'(OUT_MIN)) begin
                n_out[i] = DW'(OUT_MIN);
                n_sat = 1'b1;
            end else begin
                n_out[i] = DW'(v);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_m[i]    <= MW'($signed({1'b0, i_root}) * w_n[i]);
                r1_perp[i] <= w_p[i];
                r2_out[i]  <= n_out[i];
            end
            r1_sat <= i_lane.sat;
            r2_sat <= n_sat;
        end
    end

    assign o_valid = r_v[1];
    assign o_out   = r2_out;
    assign o_sat   = r2_sat;

endmodule

FILE: test/refract_direction_vector_tb.sv
// Self-checking testbench for the Snell refraction direction pipeline.
module refract_direction_vector_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [19:0] dx, dy, dz, nx, ny, nz;
        logic [18:0] eta;
    } t_ray;

    typedef struct packed {
        logic [19:0] ox, oy, oz;
        logic        sat;
    } t_refr;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [19:0] i_dir_x = '0, i_dir_y = '0, i_dir_z = '0;
    logic [19:0] i_norm_x = '0, i_norm_y = '0, i_norm_z = '0;
    logic [18:0] i_eta_ratio = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [19:0] o_out_x, o_out_y, o_out_z;
    logic        o_saturated;

    refract_direction_vector dut (.*);

    t_ray   ray_q[$];
    t_refr  refr_q[$];
    int     mismatches = 0;
    int     cycles = 0;
    bit     stim_done = 1'b0;
    bit     hold_for_drain = 1'b0;
    int     burst_left = 0;
    int     gap_left = 0;
    int     stall_phase = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint rshift_floor(longint y);
        return y >>> 16;
    endfunction

    function automatic longint round_q(longint x);
        return rshift_floor(x + 64'sd32768);
    endfunction

    function automatic longint sqrt_floor(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic t_refr refract(t_ray a);
        longint d[3], n[3], p[3], dot, c, s, v, rt, eta;
        longint unsigned pp, diff, one2;
        t_refr res;
        bit sat;
        d[0] = longint'(signed'(a.dx)); d[1] = longint'(signed'(a.dy));
        d[2] = longint'(signed'(a.dz));
        n[0] = longint'(signed'(a.nx)); n[1] = longint'(signed'(a.ny));
        n[2] = longint'(signed'(a.nz));
        eta = longint'({45'd0, a.eta});
        sat = 1'b0;
        dot = d[0] * n[0] + d[1] * n[1] + d[2] * n[2];
        c = round_q(-dot);
        if (c > 64'sd65536) c = 64'sd65536;
        pp = 0;
        for (int i = 0; i < 3; i++) begin
            s = d[i] + round_q(c * n[i]);
            p[i] = round_q(eta * s);
            if (p[i] > 64'sd2147483647) begin
                p[i] = 64'sd2147483647; sat = 1'b1;
            end else if (p[i] < -64'sd2147483647) begin
                p[i] = -64'sd2147483647; sat = 1'b1;
            end
            pp = pp + longint'(p[i] * p[i]);
        end
        one2 = 64'd1 << 32;
        diff = (pp >= one2) ? pp - one2 : one2 - pp;
        rt = sqrt_floor(diff);
        for (int i = 0; i < 3; i++) begin
            v = p[i] - round_q(rt * n[i]);
            if (v > 64'sd524287) begin
                v = 64'sd524287; sat = 1'b1;
            end else if (v < -64'sd524288) begin
                v = -64'sd524288; sat = 1'b1;
            end
            if (i == 0) res.ox = v[19:0];
            if (i == 1) res.oy = v[19:0];
            if (i == 2) res.oz = v[19:0];
        end
        res.sat = sat;
        return res;
    endfunction

    function automatic logic [19:0] unit_comp(int sel);
        case (sel)
            0: return 20'sd65536;
            1: return -20'sd65536;
            2: return 20'(46341);
            3: return -20'sd46341;
            default: return 20'(int'($urandom_range(0, 131072)) - 65536);
        endcase
    endfunction

    function automatic t_ray random_ray();
        t_ray a;
        int mode;
        logic [159:0] rb;
        mode = $urandom_range(0, 9);
        if (mode < 6) begin
            a.dx = unit_comp($urandom_range(0, 5)); a.dy = unit_comp($urandom_range(0, 5));
            a.dz = unit_comp($urandom_range(0, 5)); a.nx = unit_comp($urandom_range(0, 5));
            a.ny = unit_comp($urandom_range(0, 5)); a.nz = unit_comp($urandom_range(0, 5));
            a.eta = 19'($urandom_range(16384, 196608));
        end else begin
            rb = {$urandom, $urandom, $urandom, $urandom, $urandom};
            a = rb[138:0];
            if (mode == 9) a.eta = 19'($urandom_range(0, 3) == 0 ? 19'h7FFFF : 19'd0);
        end
        return a;
    endfunction

    initial begin
        t_ray a;
        logic [19:0] ext[4];
        ext[0] = 20'h7FFFF; ext[1] = 20'h80000; ext[2] = 20'h00000; ext[3] = 20'hFFFFF;
        for (int k = 0; k < 4; k++) begin
            a = '{ext[k], ext[k], ext[k], ext[k], ext[k], ext[k], 19'h7FFFF};
            ray_q.push_back(a);
            a = '{ext[k], ext[(k + 1) % 4], ext[k], ext[(k + 2) % 4], ext[k], ext[k], 19'd0};
            ray_q.push_back(a);
        end
        // head-on, grazing, total internal reflection, plain refraction, unnormalized inputs, ray along the normal
        ray_q.push_back('{20'd0, 20'd0, -20'sd65536, 20'd0, 20'd0, 20'sd65536, 19'd65536});
        ray_q.push_back('{20'sd65536, 20'd0, 20'd0, 20'd0, 20'd0, 20'sd65536, 19'd65536});
        ray_q.push_back('{20'sd46341, 20'd0, -20'sd46341, 20'd0, 20'd0, 20'sd65536,
                          19'd98304});
        ray_q.push_back('{20'sd46341, 20'd0, -20'sd46341, 20'd0, 20'd0, 20'sd65536,
                          19'd45000});
        ray_q.push_back('{20'sd200000, 20'sd3000, -20'sd100000, 20'sd1000, -20'sd70000,
                          20'sd300000, 19'd80000});
        ray_q.push_back('{20'd0, 20'd0, 20'sd65536, 20'd0, 20'd0, 20'sd65536, 19'd65536});
        for (int i = 0; i < 900; i++) ray_q.push_back(random_ray());
        wait (ray_q.size() == 0);
        hold_for_drain = 1'b1;
        wait (!i_valid && refr_q.size() == 0);
        hold_for_drain = 1'b0;
        for (int i = 0; i < 940; i++) ray_q.push_back(random_ray());
        wait (ray_q.size() == 0 && !i_valid);
        stim_done = 1'b1;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == 8) i_rst_n <= 1'b1;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                refr_q.push_back(refract({i_dir_x, i_dir_y, i_dir_z, i_norm_x, i_norm_y,
                                          i_norm_z, i_eta_ratio}));
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_valid <= 1'b0;
                end else if (ray_q.size() > 0 && !hold_for_drain) begin
                    {i_dir_x, i_dir_y, i_dir_z, i_norm_x, i_norm_y, i_norm_z,
                     i_eta_ratio} <= ray_q.pop_front();
                    i_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
            stall_phase <= (stall_phase + 1) % 300;
            i_stall <= (stall_phase < 100) ? 1'b0 :
                       (stall_phase < 200) ? ($urandom_range(0, 3) == 0) :
                       ($urandom_range(0, 1) == 0);
        end
    end

    always @(posedge i_clk) begin
        t_refr exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (refr_q.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) $display("unexpected transfer at cycle %0d", cycles);
            end else begin
                exp_r = refr_q.pop_front();
                if (exp_r != {o_out_x, o_out_y, o_out_z, o_saturated}) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: exp %h %h %h %b got %h %h %h %b",
                                 exp_r.ox, exp_r.oy, exp_r.oz, exp_r.sat,
                                 o_out_x, o_out_y, o_out_z, o_saturated);
                end
            end
        end
    end

    initial begin
        fork
            begin
                wait (stim_done && refr_q.size() == 0);
                repeat (100) @(posedge i_clk);
                if (mismatches == 0 && refr_q.size() == 0) $display("RESULT: OK");
                else $display("RESULT: ERROR");
                $finish;
            end
            begin
                wait (cycles >= 400000);
                $display("RESULT: ERROR");
                $finish;
            end
        join_none
    end
endmodule
